// ----- hdl/tpr_pkg.sv -----
package tpr_pkg;

   // Encoder and set-point geometry.
   localparam int ENCODER_COUNTS = 8192;
   localparam int ENC_BITS       = 13;
   localparam int HALF_TURN      = ENCODER_COUNTS / 2;
   localparam int SP_BITS        = 48;

   // Fixed-point and square-root constants.
   localparam logic [31:0] ONE_Q16 = 32'd65536;
   localparam int CAP_LIMIT_BITS   = 47;
   localparam int ROOT_STEPS       = 32;
   localparam int ROOT_CNT_BITS    = $clog2(ROOT_STEPS);

   // Register reset values.
   localparam logic [31:0] CRUISE_RESET = 32'd44739242;
   localparam logic [23:0] ACCEL_RESET  = 24'd196608;
   localparam logic [15:0] ARRIVE_RESET = 16'd300;
   localparam logic [15:0] PHASE_RESET  = 16'd6000;
   localparam logic [15:0] STALL_RESET  = 16'd500;

   // Item modes.
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   typedef enum logic [2:0] {
      CSR_CRUISE = 3'd0,
      CSR_ACCEL  = 3'd1,
      CSR_ARRIVE = 3'd2,
      CSR_PHASE  = 3'd3,
      CSR_STALL  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      STS_IDLE     = 3'd0,
      STS_STARTED  = 3'd1,
      STS_MOVING   = 3'd2,
      STS_ARRIVED  = 3'd3,
      STS_TIMEOUT  = 3'd4,
      STS_STALLED  = 3'd5,
      STS_REJECTED = 3'd6
   } move_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED,
      ST_REM_LO,
      ST_REM_HI,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_CLAMP,
      ST_STEP,
      ST_WRITE
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SPEED,
      OP_REM_LO,
      OP_REM_HI,
      OP_ROOT_INIT,
      OP_ROOT,
      OP_CLAMP,
      OP_STEP,
      OP_WRITE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      req_ready;
   } dp_cmd_type;

   typedef struct packed {
      logic item_mode;
      logic running;
      logic out_free;
   } dp_stat_type;

endpackage

// ----- hdl/tpr_req_if.sv -----
interface tpr_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [3:0]         axis;
   logic signed [31:0] distance_counts;
   logic [12:0]        encoder_position;
   logic [15:0]        elapsed_ms;

   modport source (output valid, mode, axis, distance_counts, encoder_position, elapsed_ms,
                   input ready);
   modport sink (input valid, mode, axis, distance_counts, encoder_position, elapsed_ms,
                 output ready);
endinterface

// ----- hdl/tpr_rsp_if.sv -----
interface tpr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] target_position;
   logic [31:0]        planned_speed;
   logic [3:0]         move_axis;
   logic [2:0]         status;

   modport source (output valid, target_position, planned_speed, move_axis, status,
                   input ready);
   modport sink (input valid, target_position, planned_speed, move_axis, status,
                 output ready);
endinterface

// ----- hdl/tpr_csr_if.sv -----
interface tpr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/trapezoid_position_ramp.sv -----
// Position set-point generator for one motor axis with a trapezoidal speed profile. A start
// word fixes the signed distance, axis (1 to 8) and encoder reading; each tick word advances
// the speed by acceleration times elapsed ms, caps it at cruise speed and at the stopping
// speed sqrt(2 * acceleration * remaining), and steps the set-point. A start word, or a tick
// while no move runs, goes straight to the write state. A tick during a move runs the speed,
// remainder, root, clamp and step states: a shared 32 x 24 multiplier is used four times
// and the root is found one bit per cycle. A new word is accepted the cycle after the
// previous result is placed in the output register, even if that result has not yet been
// taken. Registers may be written at any time that no word is in flight.
module trapezoid_position_ramp
   import tpr_pkg::*;
(
   input logic     clock,
   input logic     reset,
   tpr_req_if.sink   req_chan,
   tpr_rsp_if.source rsp_chan,
   tpr_csr_if.sink   csr_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Register writes are always taken.
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = cmd.req_ready;

   tpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_mode         (req_chan.mode),
      .in_axis         (req_chan.axis),
      .in_distance     (req_chan.distance_counts),
      .in_encoder      (req_chan.encoder_position),
      .in_elapsed      (req_chan.elapsed_ms),
      .csr_write       (csr_chan.valid),
      .csr_index       (csr_chan.index),
      .csr_data        (csr_chan.data),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .target_position (rsp_chan.target_position),
      .planned_speed   (rsp_chan.planned_speed),
      .move_axis       (rsp_chan.move_axis),
      .status          (rsp_chan.status)
   );

   // An accepted word closes the input until its result is written.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("input accepted twice in a row");

   // A move that ends always reports zero planned speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == STS_ARRIVED || rsp_chan.status == STS_TIMEOUT
                         || rsp_chan.status == STS_STALLED) |-> rsp_chan.planned_speed == '0)
      else $error("ending result with non-zero speed");

   // Only valid axes, or zero from reset until a start is taken, are ever held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.move_axis <= 4'd8)
      else $error("held axis out of range");

endmodule

// ----- hdl/tpr_ctrl.sv -----
module tpr_ctrl
   import tpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type             state_ff, state_in;
   logic [ROOT_CNT_BITS-1:0]   count_ff, count_in;

   // State and root iteration counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.item_mode == MODE_START || !stat.running) state_in = ST_WRITE;
               else state_in = ST_SPEED;
            end
         end
         ST_SPEED:     state_in = ST_REM_LO;
         ST_REM_LO:    state_in = ST_REM_HI;
         ST_REM_HI:    state_in = ST_ROOT_INIT;
         ST_ROOT_INIT: begin
            state_in = ST_ROOT;
            count_in = '0;
         end
         ST_ROOT: begin
            count_in = count_ff + 1'b1;
            if (count_ff == ROOT_CNT_BITS'(ROOT_STEPS - 1)) state_in = ST_CLAMP;
         end
         ST_CLAMP:     state_in = ST_STEP;
         ST_STEP:      state_in = ST_WRITE;
         ST_WRITE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op        = OP_NONE;
      cmd.req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_SPEED:     cmd.op = OP_SPEED;
         ST_REM_LO:    cmd.op = OP_REM_LO;
         ST_REM_HI:    cmd.op = OP_REM_HI;
         ST_ROOT_INIT: cmd.op = OP_ROOT_INIT;
         ST_ROOT:      cmd.op = OP_ROOT;
         ST_CLAMP:     cmd.op = OP_CLAMP;
         ST_STEP:      cmd.op = OP_STEP;
         ST_WRITE: begin
            if (stat.out_free) cmd.op = OP_WRITE;
         end
         default:      cmd.op = OP_NONE;
      endcase
   end

endmodule

// ----- hdl/tpr_datapath.sv -----
module tpr_datapath
   import tpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic               in_mode,
   input  logic [3:0]         in_axis,
   input  logic [31:0]        in_distance,
   input  logic [12:0]        in_encoder,
   input  logic [15:0]        in_elapsed,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic signed [47:0] target_position,
   output logic [31:0]        planned_speed,
   output logic [3:0]         move_axis,
   output logic [2:0]         status
);

   // Configuration registers.
   logic [31:0] cruise_ff, cruise_in;
   logic [23:0] accel_ff, accel_in;
   logic [15:0] arrive_ff, arrive_in;
   logic [15:0] phase_ff, phase_in;
   logic [15:0] stall_ff, stall_in;

   // Move state.
   logic [SP_BITS-1:0]  set_point_ff, set_point_in;
   logic [SP_BITS-1:0]  travelled_ff, travelled_in;
   logic [ENC_BITS-1:0] prev_enc_ff, prev_enc_in;
   logic [31:0]         speed_ff, speed_in;
   logic [31:0]         dist_ff, dist_in;
   logic                reverse_ff, reverse_in;
   logic [31:0]         move_time_ff, move_time_in;
   logic [31:0]         still_time_ff, still_time_in;
   logic                running_ff, running_in;
   logic [3:0]          axis_held_ff, axis_held_in;

   // Latched word.
   logic                mode_ff, mode_in;
   logic [3:0]          axis_ff, axis_in;
   logic [31:0]         draw_ff, draw_in;
   logic [ENC_BITS-1:0] enc_ff, enc_in;
   logic [15:0]         dt_ff, dt_in;

   // Working registers of one tick.
   logic signed [SP_BITS:0] p_old_ff, p_old_in;
   logic signed [SP_BITS:0] prog_new_ff, prog_new_in;
   logic [40:0]             v_ff, v_in;
   logic [SP_BITS-1:0]      travel_new_ff, travel_new_in;
   logic [SP_BITS-1:0]      rem_ff, rem_in;
   logic [47:0]             lo_ff, lo_in;
   logic [71:0]             prod_ff, prod_in;
   logic                    cap_ok_ff, cap_ok_in;
   logic [63:0]             x_ff, x_in;
   logic [34:0]             r_ff, r_in;
   logic [31:0]             q_ff, q_in;
   logic [31:0]             vfin_ff, vfin_in;
   logic [31:0]             step_ff, step_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SP_BITS-1:0] out_sp_ff, out_sp_in;
   logic [31:0]       out_speed_ff, out_speed_in;
   logic [3:0]        out_axis_ff, out_axis_in;
   logic [2:0]        out_status_ff, out_status_in;

   // Shared multiplier and helpers.
   logic [31:0] mul_a;
   logic [23:0] mul_b;
   logic [55:0] mul_p;
   logic signed [13:0]      d_raw, d_fold;
   logic signed [SP_BITS:0] dist_s, rem_diff, trav_s, tnew_s;
   logic [36:0]             root_part;
   logic [33:0]             root_trial;
   logic [31:0]             v_clamp, mag;
   logic [32:0]             move_sum, still_sum;
   logic [31:0]             move_new, still_new;
   logic signed [33:0]      arrive_limit;
   logic [SP_BITS-1:0]      sp_tick;
   move_status_type         tick_status;

   assign stat.item_mode = in_mode;
   assign stat.running   = running_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign target_position = $signed(out_sp_ff);
   assign planned_speed   = out_speed_ff;
   assign move_axis       = out_axis_ff;
   assign status          = out_status_ff;

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SPEED: begin
            mul_a = {8'd0, accel_ff};
            mul_b = {8'd0, dt_ff};
         end
         OP_REM_LO: begin
            mul_a = {8'd0, accel_ff};
            mul_b = rem_ff[23:0];
         end
         OP_REM_HI: begin
            mul_a = {8'd0, accel_ff};
            mul_b = rem_ff[47:24];
         end
         OP_STEP: begin
            mul_a = vfin_ff;
            mul_b = {8'd0, dt_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Encoder delta folded into half a turn either way.
   always_comb begin
      d_raw  = $signed({1'b0, enc_ff}) - $signed({1'b0, prev_enc_ff});
      d_fold = d_raw;
      if (d_raw > $signed(14'(HALF_TURN))) d_fold = d_raw - $signed(14'(ENCODER_COUNTS));
      else if (d_raw < -$signed(14'(HALF_TURN)))
         d_fold = d_raw + $signed(14'(ENCODER_COUNTS));
   end

   // Distance still to go, from the progress before this tick.
   assign dist_s   = $signed({17'd0, dist_ff});
   assign rem_diff = dist_s - p_old_ff;
   assign trav_s   = (SP_BITS+1)'($signed(travelled_ff));
   assign tnew_s   = (SP_BITS+1)'($signed(travel_new_ff));

   // One restoring square-root step: two radicand bits in, one root bit out.
   assign root_part  = {r_ff, x_ff[63:62]};
   assign root_trial = {q_ff, 2'b01};

   // Speed after the stopping cap and the floor of one count per ms.
   always_comb begin
      v_clamp = v_ff[31:0];
      if (cap_ok_ff && v_clamp > q_ff) v_clamp = q_ff;
      if (v_clamp < ONE_Q16) v_clamp = ONE_Q16;
   end

   // Tick commit values.
   always_comb begin
      sp_tick      = reverse_ff ? set_point_ff - SP_BITS'(step_ff)
                                : set_point_ff + SP_BITS'(step_ff);
      move_sum     = {1'b0, move_time_ff} + 33'(dt_ff);
      move_new     = move_sum[32] ? 32'hFFFF_FFFF : move_sum[31:0];
      still_sum    = {1'b0, still_time_ff} + 33'(dt_ff);
      still_new    = (enc_ff != prev_enc_ff) ? 32'd0
                   : (still_sum[32] ? 32'hFFFF_FFFF : still_sum[31:0]);
      arrive_limit = $signed({2'b00, dist_ff}) - $signed({18'd0, arrive_ff});
      if (move_new > {16'd0, phase_ff}) tick_status = STS_TIMEOUT;
      else if (still_new > {16'd0, stall_ff}) tick_status = STS_STALLED;
      else if (prog_new_ff >= (SP_BITS+1)'(arrive_limit)) tick_status = STS_ARRIVED;
      else tick_status = STS_MOVING;
      mag = draw_ff[31] ? 32'd0 - draw_ff : draw_ff;
   end

   // Next values of all registers.
   always_comb begin
      cruise_in     = cruise_ff;
      accel_in      = accel_ff;
      arrive_in     = arrive_ff;
      phase_in      = phase_ff;
      stall_in      = stall_ff;
      set_point_in  = set_point_ff;
      travelled_in  = travelled_ff;
      prev_enc_in   = prev_enc_ff;
      speed_in      = speed_ff;
      dist_in       = dist_ff;
      reverse_in    = reverse_ff;
      move_time_in  = move_time_ff;
      still_time_in = still_time_ff;
      running_in    = running_ff;
      axis_held_in  = axis_held_ff;
      mode_in       = mode_ff;
      axis_in       = axis_ff;
      draw_in       = draw_ff;
      enc_in        = enc_ff;
      dt_in         = dt_ff;
      p_old_in      = p_old_ff;
      prog_new_in   = prog_new_ff;
      v_in          = v_ff;
      travel_new_in = travel_new_ff;
      rem_in        = rem_ff;
      lo_in         = lo_ff;
      prod_in       = prod_ff;
      cap_ok_in     = cap_ok_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      q_in          = q_ff;
      vfin_in       = vfin_ff;
      step_in       = step_ff;
      out_sp_in     = out_sp_ff;
      out_speed_in  = out_speed_ff;
      out_axis_in   = out_axis_ff;
      out_status_in = out_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // The user must write registers only while no word is in flight; the block does not enforce it.
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CRUISE: cruise_in = csr_data;
            CSR_ACCEL:  accel_in  = csr_data[23:0];
            CSR_ARRIVE: arrive_in = csr_data[15:0];
            CSR_PHASE:  phase_in  = csr_data[15:0];
            CSR_STALL:  stall_in  = csr_data[15:0];
            default:    cruise_in = cruise_ff;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            mode_in  = in_mode;
            axis_in  = in_axis;
            draw_in  = in_distance;
            enc_in   = in_encoder;
            dt_in    = (in_elapsed == 16'd0) ? 16'd1 : in_elapsed;
            p_old_in = reverse_ff ? -trav_s : trav_s;
         end
         OP_SPEED: begin
            v_in          = {9'd0, speed_ff} + {1'b0, mul_p[39:0]};
            travel_new_in = travelled_ff + SP_BITS'(d_fold);
            rem_in        = (p_old_ff < dist_s) ? rem_diff[SP_BITS-1:0] : '0;
         end
         OP_REM_LO: begin
            lo_in       = mul_p[47:0];
            prog_new_in = reverse_ff ? -tnew_s : tnew_s;
            if (v_ff > {9'd0, cruise_ff}) v_in = {9'd0, cruise_ff};
         end
         OP_REM_HI: begin
            prod_in = {24'd0, lo_ff} + {mul_p[47:0], 24'd0};
         end
         OP_ROOT_INIT: begin
            cap_ok_in = (rem_ff != '0) && (accel_ff != 24'd0)
                        && (prod_ff[71:CAP_LIMIT_BITS] == '0);
            x_in      = {prod_ff[CAP_LIMIT_BITS-1:0], 17'd0};
            r_in      = '0;
            q_in      = '0;
         end
         OP_ROOT: begin
            x_in = {x_ff[61:0], 2'b00};
            if (root_part >= {3'd0, root_trial}) begin
               r_in = 35'(root_part - {3'd0, root_trial});
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               r_in = root_part[34:0];
               q_in = {q_ff[30:0], 1'b0};
            end
         end
         OP_CLAMP: vfin_in = v_clamp;
         OP_STEP:  step_in = mul_p[47:16];
         OP_WRITE: begin
            rsp_valid_in = 1'b1;
            if (mode_ff == MODE_START) begin
               if (!(axis_ff inside {[4'd1:4'd8]})) begin
                  out_status_in = STS_REJECTED;
               end else if (mag == 32'd0) begin
                  out_status_in = running_ff ? STS_MOVING : STS_IDLE;
               end else begin
                  axis_held_in  = axis_ff;
                  set_point_in  = SP_BITS'(enc_ff);
                  travelled_in  = '0;
                  prev_enc_in   = enc_ff;
                  speed_in      = '0;
                  dist_in       = mag;
                  reverse_in    = draw_ff[31];
                  move_time_in  = '0;
                  still_time_in = '0;
                  if (mag <= {16'd0, arrive_ff}) begin
                     running_in    = 1'b0;
                     out_status_in = STS_ARRIVED;
                  end else begin
                     running_in    = 1'b1;
                     out_status_in = STS_STARTED;
                  end
               end
            end else if (!running_ff) begin
               out_status_in = STS_IDLE;
            end else begin
               travelled_in  = travel_new_ff;
               still_time_in = still_new;
               prev_enc_in   = enc_ff;
               move_time_in  = move_new;
               out_status_in = tick_status;
               if (tick_status == STS_MOVING) begin
                  set_point_in = sp_tick;
                  speed_in     = vfin_ff;
               end else begin
                  set_point_in = SP_BITS'(enc_ff);
                  speed_in     = '0;
                  running_in   = 1'b0;
               end
            end
            out_sp_in    = set_point_in;
            out_speed_in = speed_in;
            out_axis_in  = axis_held_in;
         end
         default: begin
            v_in = v_ff;
         end
      endcase
   end

   // Configuration, move state and output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_ff     <= CRUISE_RESET;
         accel_ff      <= ACCEL_RESET;
         arrive_ff     <= ARRIVE_RESET;
         phase_ff      <= PHASE_RESET;
         stall_ff      <= STALL_RESET;
         set_point_ff  <= '0;
         travelled_ff  <= '0;
         prev_enc_ff   <= '0;
         speed_ff      <= '0;
         dist_ff       <= '0;
         reverse_ff    <= 1'b0;
         move_time_ff  <= '0;
         still_time_ff <= '0;
         running_ff    <= 1'b0;
         axis_held_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cruise_ff     <= cruise_in;
         accel_ff      <= accel_in;
         arrive_ff     <= arrive_in;
         phase_ff      <= phase_in;
         stall_ff      <= stall_in;
         set_point_ff  <= set_point_in;
         travelled_ff  <= travelled_in;
         prev_enc_ff   <= prev_enc_in;
         speed_ff      <= speed_in;
         dist_ff       <= dist_in;
         reverse_ff    <= reverse_in;
         move_time_ff  <= move_time_in;
         still_time_ff <= still_time_in;
         running_ff    <= running_in;
         axis_held_ff  <= axis_held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      axis_ff       <= axis_in;
      draw_ff       <= draw_in;
      enc_ff        <= enc_in;
      dt_ff         <= dt_in;
      p_old_ff      <= p_old_in;
      prog_new_ff   <= prog_new_in;
      v_ff          <= v_in;
      travel_new_ff <= travel_new_in;
      rem_ff        <= rem_in;
      lo_ff         <= lo_in;
      prod_ff       <= prod_in;
      cap_ok_ff     <= cap_ok_in;
      x_ff          <= x_in;
      r_ff          <= r_in;
      q_ff          <= q_in;
      vfin_ff       <= vfin_in;
      step_ff       <= step_in;
      out_sp_ff     <= out_sp_in;
      out_speed_ff  <= out_speed_in;
      out_axis_ff   <= out_axis_in;
      out_status_ff <= out_status_in;
   end

endmodule
